// File: hdl/phfd_pkg.sv
`default_nettype none

package phfd_pkg;

  // Largest hit buffer the design supports; sizes the hit count carried in a job.
  localparam int MAX_HIT_DEPTH = 32;
  localparam int HIT_CNT_W = $clog2(MAX_HIT_DEPTH + 1);

  // One buffered hit: column, row, time over threshold.
  localparam int HIT_W = 25;

  // Top five bits of a word select its class.
  localparam logic [4:0] TAG_TIMESTAMP = 5'b01001;
  localparam logic [4:0] TAG_DATA      = 5'b01000;

  // Control codes carried in a 9-bit data slice.
  localparam logic [8:0] CODE_SOF  = 9'h1bc;
  localparam logic [8:0] CODE_EOF  = 9'h17c;
  localparam logic [8:0] CODE_IDLE = 9'h13c;

  localparam logic [15:0] ERR_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_HIT       = 2'd0,
    KIND_TRIGGER   = 2'd1,
    KIND_TIMESTAMP = 2'd2,
    KIND_UNKNOWN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SLICE,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_DRAIN
  } back_state_t;

  // Work handed from the front to the back. A hit job means "send out the
  // first hits entries of the hit store".
  typedef struct packed {
    kind_t                 kind;
    logic [30:0]           info;
    logic [15:0]           errors;
    logic [HIT_CNT_W-1:0]  hits;
  } job_t;

  typedef struct packed {
    kind_t        kind;
    logic [8:0]   column;
    logic [8:0]   row;
    logic [6:0]   tot;
    logic [15:0]  trigger_number;
    logic [14:0]  trigger_time;
    logic [26:0]  time_stamp;
    logic [15:0]  errors;
    logic         last;
  } result_t;

  // Gray code to binary, 7 bits.
  function automatic logic [6:0] gray7(input logic [6:0] g);
    logic [6:0] b;
    b[6] = g[6];
    for (int i = 5; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/phfd_ram.sv
`default_nettype none

module phfd_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/phfd_front.sv
`default_nettype none

module phfd_front #(
  parameter int HIT_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          raw_word,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 q_full,
  output logic                      q_push,
  output phfd_pkg::job_t            q_job,
  input  wire logic                 drain_done,
  output logic                      ram_we,
  output logic [((HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1)-1:0] ram_waddr,
  output logic [phfd_pkg::HIT_W-1:0] ram_wdata
);

  localparam int AW  = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
  localparam int HCW = $clog2(HIT_DEPTH + 1);
  localparam int CW  = phfd_pkg::HIT_CNT_W;

  phfd_pkg::front_state_t state, state_next;

  logic [30:0]     word_info;
  phfd_pkg::kind_t job_kind, kind_in;
  logic [1:0]      slice_idx;
  logic            flush_pending;

  logic            in_frame, in_frame_next;
  logic [1:0]      slice_step, slice_step_next;
  logic [8:0]      partial_column, partial_column_next;
  logic [6:0]      leading_edge, leading_edge_next;
  logic            trailing_high_bit, trailing_high_bit_next;
  logic            row_high_bit, row_high_bit_next;
  logic [6:0]      tot_value, tot_value_next;
  logic [HCW-1:0]  hit_count, hit_count_next;
  logic [15:0]     errors, errors_next;
  logic [CW-1:0]   flush_cnt, flush_cnt_next;

  logic            slice_go;
  logic            store_hit;
  logic            bump;
  logic [8:0]      d;
  logic [6:0]      trailing_edge;

  // Word classification at the input.
  always_comb begin
    if (raw_word[31:27] == phfd_pkg::TAG_TIMESTAMP) begin
      kind_in = phfd_pkg::KIND_TIMESTAMP;
    end else if (raw_word[31:27] == phfd_pkg::TAG_DATA) begin
      kind_in = phfd_pkg::KIND_HIT;
    end else if (raw_word[31]) begin
      kind_in = phfd_pkg::KIND_TRIGGER;
    end else begin
      kind_in = phfd_pkg::KIND_UNKNOWN;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      phfd_pkg::F_IDLE: begin
        if (in_valid) begin
          state_next = (kind_in == phfd_pkg::KIND_HIT) ? phfd_pkg::F_SLICE : phfd_pkg::F_PUSH;
        end
      end
      phfd_pkg::F_SLICE: begin
        if (slice_go && slice_idx == 2'd2) begin
          state_next = (flush_cnt_next != '0) ? phfd_pkg::F_PUSH : phfd_pkg::F_IDLE;
        end
      end
      phfd_pkg::F_PUSH: begin
        if (!q_full) begin
          state_next = phfd_pkg::F_IDLE;
        end
      end
      default: state_next = phfd_pkg::F_IDLE;
    endcase
  end

  // State outputs. Slices wait while an earlier flush still reads the store.
  always_comb begin
    in_ready = 1'b0;
    slice_go = 1'b0;
    q_push   = 1'b0;
    unique case (state)
      phfd_pkg::F_IDLE:  in_ready = 1'b1;
      phfd_pkg::F_SLICE: slice_go = !flush_pending;
      phfd_pkg::F_PUSH:  q_push   = !q_full;
      default: ;
    endcase
  end

  always_comb begin
    q_job.kind   = job_kind;
    q_job.info   = word_info;
    q_job.errors = errors;
    q_job.hits   = flush_cnt;
  end

  // One 9-bit slice, most significant first.
  always_comb begin
    case (slice_idx)
      2'd0:    d = word_info[26:18];
      2'd1:    d = word_info[17:9];
      default: d = word_info[8:0];
    endcase
  end

  assign trailing_edge = phfd_pkg::gray7({trailing_high_bit, d[7:2]});

  always_comb begin
    in_frame_next          = in_frame;
    slice_step_next        = slice_step;
    partial_column_next    = partial_column;
    leading_edge_next      = leading_edge;
    trailing_high_bit_next = trailing_high_bit;
    row_high_bit_next      = row_high_bit;
    tot_value_next         = tot_value;
    hit_count_next         = hit_count;
    flush_cnt_next         = flush_cnt;
    store_hit              = 1'b0;
    bump                   = 1'b0;
    if (d == phfd_pkg::CODE_SOF) begin
      bump            = in_frame;
      in_frame_next   = 1'b1;
      slice_step_next = 2'd0;
    end else if (d == phfd_pkg::CODE_EOF) begin
      if (!in_frame) begin
        bump = 1'b1;
      end else begin
        if (hit_count != '0) begin
          flush_cnt_next = CW'(hit_count);
        end
        hit_count_next = '0;
      end
      in_frame_next = 1'b0;
    end else if (d != phfd_pkg::CODE_IDLE && in_frame) begin
      case (slice_step)
        2'd0: begin
          partial_column_next = {d[7:0], 1'b0};
          slice_step_next     = 2'd1;
        end
        2'd1: begin
          leading_edge_next      = phfd_pkg::gray7(d[7:1]);
          trailing_high_bit_next = d[0];
          slice_step_next        = 2'd2;
        end
        2'd2: begin
          tot_value_next      = trailing_edge - leading_edge;
          row_high_bit_next   = d[0];
          partial_column_next = partial_column + 9'(d[1]);
          slice_step_next     = 2'd3;
        end
        default: begin
          if (hit_count < HCW'(HIT_DEPTH)) begin
            store_hit      = 1'b1;
            hit_count_next = hit_count + 1'b1;
          end else begin
            bump = 1'b1;
          end
          slice_step_next = 2'd0;
        end
      endcase
    end
    errors_next = (bump && errors != phfd_pkg::ERR_MAX) ? errors + 16'd1 : errors;
  end

  assign ram_we    = slice_go && store_hit;
  assign ram_waddr = hit_count[AW-1:0];
  assign ram_wdata = {partial_column, row_high_bit, d[7:0], tot_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= phfd_pkg::F_IDLE;
      slice_idx         <= 2'd0;
      flush_pending     <= 1'b0;
      flush_cnt         <= '0;
      in_frame          <= 1'b0;
      slice_step        <= 2'd0;
      partial_column    <= '0;
      leading_edge      <= '0;
      trailing_high_bit <= 1'b0;
      row_high_bit      <= 1'b0;
      tot_value         <= '0;
      hit_count         <= '0;
      errors            <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        slice_idx <= 2'd0;
        flush_cnt <= '0;
      end
      if (slice_go) begin
        slice_idx         <= slice_idx + 2'd1;
        flush_cnt         <= flush_cnt_next;
        in_frame          <= in_frame_next;
        slice_step        <= slice_step_next;
        partial_column    <= partial_column_next;
        leading_edge      <= leading_edge_next;
        trailing_high_bit <= trailing_high_bit_next;
        row_high_bit      <= row_high_bit_next;
        tot_value         <= tot_value_next;
        hit_count         <= hit_count_next;
        errors            <= errors_next;
      end
      if (q_push && job_kind == phfd_pkg::KIND_HIT) begin
        flush_pending <= 1'b1;
      end else if (drain_done) begin
        flush_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_info <= raw_word[30:0];
      job_kind  <= kind_in;
    end
  end

endmodule

`default_nettype wire

// File: hdl/phfd_queue.sv
`default_nettype none

module phfd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire phfd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output phfd_pkg::job_t      head
);

  phfd_pkg::job_t entries [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hdl/phfd_back.sv
`default_nettype none

module phfd_back #(
  parameter int HIT_DEPTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire phfd_pkg::job_t        q_job,
  output logic                       q_pop,
  output logic [((HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1)-1:0] ram_raddr,
  input  wire logic [phfd_pkg::HIT_W-1:0] ram_rdata,
  output logic                       drain_done,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output phfd_pkg::result_t          res
);

  localparam int AW = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
  localparam int CW = phfd_pkg::HIT_CNT_W;

  phfd_pkg::back_state_t state, state_next;

  logic [CW-1:0] idx, cnt, raddr_full;
  logic [15:0]   err_hold;
  logic          out_free, load_job, load_hit;

  assign out_free  = !out_valid || out_ready;
  assign ram_raddr = raddr_full[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      phfd_pkg::B_IDLE:  if (q_pop && q_job.kind == phfd_pkg::KIND_HIT) state_next = phfd_pkg::B_DRAIN;
      phfd_pkg::B_DRAIN: if (drain_done) state_next = phfd_pkg::B_IDLE;
      default:           state_next = phfd_pkg::B_IDLE;
    endcase
  end

  // The store address runs one ahead of the hit being loaded, so a hit
  // leaves every cycle the output register is free.
  always_comb begin
    q_pop      = 1'b0;
    load_job   = 1'b0;
    load_hit   = 1'b0;
    drain_done = 1'b0;
    raddr_full = '0;
    unique case (state)
      phfd_pkg::B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          load_job = (q_job.kind != phfd_pkg::KIND_HIT);
        end
      end
      phfd_pkg::B_DRAIN: begin
        if (out_free) begin
          load_hit   = 1'b1;
          raddr_full = idx + 1'b1;
          drain_done = (idx == cnt - 1'b1);
        end else begin
          raddr_full = idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= phfd_pkg::B_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (load_job || load_hit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        idx <= '0;
      end else if (load_hit) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cnt      <= q_job.hits;
      err_hold <= q_job.errors;
    end
    if (load_job) begin
      res.kind           <= q_job.kind;
      res.column         <= '0;
      res.row            <= '0;
      res.tot            <= '0;
      res.trigger_number <= (q_job.kind == phfd_pkg::KIND_TRIGGER) ? q_job.info[15:0] : '0;
      res.trigger_time   <= (q_job.kind == phfd_pkg::KIND_TRIGGER) ? q_job.info[30:16] : '0;
      res.time_stamp     <= (q_job.kind == phfd_pkg::KIND_TIMESTAMP) ? q_job.info[26:0] : '0;
      res.errors         <= q_job.errors;
      res.last           <= 1'b1;
    end else if (load_hit) begin
      res.kind           <= phfd_pkg::KIND_HIT;
      res.column         <= ram_rdata[24:16];
      res.row            <= ram_rdata[15:7];
      res.tot            <= ram_rdata[6:0];
      res.trigger_number <= '0;
      res.trigger_time   <= '0;
      res.time_stamp     <= '0;
      res.errors         <= err_hold;
      res.last           <= drain_done;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pixel_hit_frame_decoder.sv
`default_nettype none

// Pixel hit frame decoder. Each 32-bit readout word is transferred in on the
// raw_word channel. Timestamp, trigger and unrecognised words each give one
// result; a data word is taken apart into three 9-bit slices, one per cycle
// once the previous flush has fully drained, which open and close frames and
// build hits that wait in a hit store until a proper end of frame sends them
// all out in arrival order. The front end accepts a data word, decodes its
// three slices and, when it closes a frame with hits buffered, pushes a flush
// job; other words are accepted and pushed. Buffered hits leave at one per
// cycle while the output register is free, paced by the single read port of
// the hit store. Timestamp and trigger results can pass through while the
// output side stalls, up to the depth of the two-entry job queue. Every
// result of a word carries the error count as it stands after the whole word.

module pixel_hit_frame_decoder #(
  parameter int HIT_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] raw_word,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [8:0]       column,
  output logic [8:0]       row,
  output logic [6:0]       time_over_threshold,
  output logic [15:0]      trigger_number,
  output logic [14:0]      trigger_time,
  output logic [26:0]      time_stamp,
  output logic [15:0]      error_count,
  output logic             last
);

  localparam int AW = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;

  // Jobs from the front end: one per result-producing word, where a hit job
  // stands for a whole frame flush.
  phfd_pkg::job_t    push_job, head_job;
  logic              q_push, q_full, q_pop, q_valid;
  logic              drain_done;

  // Hit store ports: the front end writes completed hits, the back end reads
  // them out during a flush.
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [phfd_pkg::HIT_W-1:0] ram_wdata, ram_rdata;

  phfd_pkg::result_t res;

  phfd_front #(
    .HIT_DEPTH (HIT_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .raw_word   (raw_word),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job),
    .drain_done (drain_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  phfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_job)
  );

  phfd_ram #(
    .WIDTH (phfd_pkg::HIT_W),
    .DEPTH (HIT_DEPTH)
  ) u_hit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  phfd_back #(
    .HIT_DEPTH (HIT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .drain_done (drain_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  // The output register in the back end drives the result ports directly.
  assign kind                = res.kind;
  assign column              = res.column;
  assign row                 = res.row;
  assign time_over_threshold = res.tot;
  assign trigger_number      = res.trigger_number;
  assign trigger_time        = res.trigger_time;
  assign time_stamp          = res.time_stamp;
  assign error_count         = res.errors;
  assign last                = res.last;

endmodule

`default_nettype wire

// File: sim/tb_pixel_hit_frame_decoder.sv
`timescale 1ns / 1ps

module tb_pixel_hit_frame_decoder;

  // The hit store depth used for this run. The full-buffer test relies on it.
  localparam int HIT_DEPTH = 32;
  localparam int RANDOM_ITEMS = 370;
  // Cycles allowed after the last expected result before the block counts as idle.
  // A data word still in the front end may have produced no result yet.
  localparam int DRAIN_CYCLES = 40;
  // Guard against a hung design. The slowest correct run is far below this.
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] raw_word = '0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  kind;
  logic [8:0]  column;
  logic [8:0]  row;
  logic [6:0]  time_over_threshold;
  logic [15:0] trigger_number;
  logic [14:0] trigger_time;
  logic [26:0] time_stamp;
  logic [15:0] error_count;
  logic        last;

  pixel_hit_frame_decoder #(
    .HIT_DEPTH(HIT_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .raw_word(raw_word),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .column(column),
    .row(row),
    .time_over_threshold(time_over_threshold),
    .trigger_number(trigger_number),
    .trigger_time(trigger_time),
    .time_stamp(time_stamp),
    .error_count(error_count),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder state as the testbench sees it. These mirror the frame flag, the
  // position within a four-slice hit, the partly built hit, the buffered hits
  // and the saturating error tally.
  // ---------------------------------------------------------------------------
  logic        frame_open;
  logic [1:0]  slice_phase;
  logic [8:0]  col_acc;
  logic [6:0]  lead_edge;
  logic        trail_msb;
  logic        row_msb;
  logic [6:0]  tot_acc;
  int          hits_held;
  logic [15:0] err_tally;
  logic [8:0]  held_col[HIT_DEPTH];
  logic [8:0]  held_row[HIT_DEPTH];
  logic [6:0]  held_tot[HIT_DEPTH];

  // Results that one word produces, before the error count and the last flag
  // are stamped on them, and the queue of all results still owed by the block.
  phfd_pkg::result_t word_results[$];
  phfd_pkg::result_t expected_results[$];

  // Slices waiting to be packed three to a data word.
  logic [8:0]  pending_slices[$];

  int          mismatches = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;
  int          cycle_count = 0;
  int          rx_cycle = 0;
  int          rx_mode = 0;

  initial begin
    frame_open = 1'b0;
    slice_phase = 2'd0;
    col_acc = '0;
    lead_edge = '0;
    trail_msb = 1'b0;
    row_msb = 1'b0;
    tot_acc = '0;
    hits_held = 0;
    err_tally = '0;
  end

  // Gray to binary: each binary bit is the XOR of all Gray bits at or above it.
  function automatic logic [6:0] gray_to_binary(input logic [6:0] g);
    logic [6:0] b;
    b = g;
    for (int i = 1; i < 7; i++) b = b ^ (g >> i);
    return b;
  endfunction

  task automatic bump_error_tally();
    if (err_tally != phfd_pkg::ERR_MAX) err_tally++;
  endtask

  // One 9-bit slice of a data word. Control codes act on the frame flag; any
  // other slice inside a frame advances the four-step hit assembly.
  task automatic decode_slice(input logic [8:0] sl);
    phfd_pkg::result_t r;
    logic [6:0]        trail;
    if (sl == phfd_pkg::CODE_SOF) begin
      // A start of frame while a frame is open is a framing error. Buffered
      // hits survive it, but a half-built hit is abandoned.
      if (frame_open) bump_error_tally();
      frame_open = 1'b1;
      slice_phase = 2'd0;
    end else if (sl == phfd_pkg::CODE_EOF) begin
      if (!frame_open) begin
        bump_error_tally();
      end else begin
        // A proper end of frame flushes the buffer in arrival order.
        for (int i = 0; i < hits_held && word_results.size() < 32; i++) begin
          r = '0;
          r.kind = phfd_pkg::KIND_HIT;
          r.column = held_col[i];
          r.row = held_row[i];
          r.tot = held_tot[i];
          word_results.insert(word_results.size(), r);
        end
        hits_held = 0;
      end
      frame_open = 1'b0;
    end else if (sl != phfd_pkg::CODE_IDLE && frame_open) begin
      case (slice_phase)
        2'd0: begin
          col_acc = {sl[7:0], 1'b0};
          slice_phase = 2'd1;
        end
        2'd1: begin
          lead_edge = gray_to_binary(sl[7:1]);
          trail_msb = sl[0];
          slice_phase = 2'd2;
        end
        2'd2: begin
          trail = gray_to_binary({trail_msb, sl[7:2]});
          tot_acc = trail - lead_edge;
          row_msb = sl[0];
          col_acc = col_acc + 9'(sl[1]);
          slice_phase = 2'd3;
        end
        default: begin
          // A completed hit is dropped with an error when the buffer is full.
          if (hits_held < HIT_DEPTH) begin
            held_col[hits_held] = col_acc;
            held_row[hits_held] = {row_msb, sl[7:0]};
            held_tot[hits_held] = tot_acc;
            hits_held++;
          end else begin
            bump_error_tally();
          end
          slice_phase = 2'd0;
        end
      endcase
    end
  endtask

  // Works out every result that one accepted word causes and queues them.
  task automatic decode_word(input logic [31:0] w);
    phfd_pkg::result_t r;
    word_results.delete();
    r = '0;
    if (w[31:27] == phfd_pkg::TAG_TIMESTAMP) begin
      r.kind = phfd_pkg::KIND_TIMESTAMP;
      r.time_stamp = w[26:0];
      word_results.insert(word_results.size(), r);
    end else if (w[31:27] == phfd_pkg::TAG_DATA) begin
      decode_slice(w[26:18]);
      decode_slice(w[17:9]);
      decode_slice(w[8:0]);
    end else if (w[31]) begin
      r.kind = phfd_pkg::KIND_TRIGGER;
      r.trigger_number = w[15:0];
      r.trigger_time = w[30:16];
      word_results.insert(word_results.size(), r);
    end else begin
      r.kind = phfd_pkg::KIND_UNKNOWN;
      word_results.insert(word_results.size(), r);
    end
    // Every result of the word carries the tally as it stands after the word.
    foreach (word_results[k]) begin
      r = word_results[k];
      r.errors = err_tally;
      r.last = (k == word_results.size() - 1);
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking. Outputs are sampled at the rising edge, before the design
  // updates them, and each transfer is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    phfd_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: kind=%0d col=%0d row=%0d err=%0d",
                   $realtime, kind, column, row, error_count);
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind || column !== want.column || row !== want.row ||
            time_over_threshold !== want.tot ||
            trigger_number !== want.trigger_number ||
            trigger_time !== want.trigger_time || time_stamp !== want.time_stamp ||
            error_count !== want.errors || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch", $realtime);
            $display({"  expected kind=%0d col=%0d row=%0d tot=%0d tn=%h tt=%h",
                      " ts=%h err=%0d last=%0b"},
                     want.kind, want.column, want.row, want.tot, want.trigger_number,
                     want.trigger_time, want.time_stamp, want.errors, want.last);
            $display({"  actual   kind=%0d col=%0d row=%0d tot=%0d tn=%h tt=%h",
                      " ts=%h err=%0d last=%0b"},
                     kind, column, row, time_over_threshold, trigger_number,
                     trigger_time, time_stamp, error_count, last);
          end
        end
      end
    end
  end

  // The receiver cycles through its own stall patterns: always ready, random
  // stalls, a short periodic stall and a long periodic stall. The pattern is
  // picked again at random during the run so that stalls land on all phases of
  // the block's work.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((rx_cycle % 7) >= 3);
      default: out_ready <= ((rx_cycle % 32) >= 20);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Sends one word. Unless steady_send is set, the sender works in bursts of
  // random length separated by random gaps. Valid stays high from one word to
  // the next inside a burst, so it is never lowered and raised in one step.
  task automatic send_word(input logic [31:0] w);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    raw_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    decode_word(w);
    words_sent++;
  endtask

  // Holds the sender off until every owed result has come back, then lets
  // the front end settle, since a data word may still be in flight with no
  // result of its own.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A slice that is never one of the control codes, for hit content.
  function automatic logic [8:0] payload_slice();
    logic [8:0] v;
    do v = 9'($urandom_range(0, 511));
    while (v == phfd_pkg::CODE_SOF || v == phfd_pkg::CODE_EOF ||
           v == phfd_pkg::CODE_IDLE);
    return v;
  endfunction

  // A slice for broken sequences: control codes appear often.
  function automatic logic [8:0] noisy_slice();
    case ($urandom_range(0, 9))
      0: return phfd_pkg::CODE_SOF;
      1: return phfd_pkg::CODE_EOF;
      2: return phfd_pkg::CODE_IDLE;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // Timestamp, trigger or unrecognised word with random content.
  function automatic logic [31:0] side_word();
    logic [31:0] w;
    case ($urandom_range(0, 2))
      0: w = {phfd_pkg::TAG_TIMESTAMP, 27'd0} | ($urandom & 32'h07FF_FFFF);
      1: w = 32'h8000_0000 | $urandom;
      default: begin
        do w = $urandom & 32'h7FFF_FFFF;
        while (w[31:27] == phfd_pkg::TAG_TIMESTAMP || w[31:27] == phfd_pkg::TAG_DATA);
      end
    endcase
    return w;
  endfunction

  task automatic queue_slice(input logic [8:0] s);
    pending_slices.insert(pending_slices.size(), s);
  endtask

  task automatic push_hit(input logic [8:0] s0, s1, s2, s3);
    queue_slice(s0);
    queue_slice(s1);
    queue_slice(s2);
    queue_slice(s3);
  endtask

  task automatic push_random_hit();
    push_hit(payload_slice(), payload_slice(), payload_slice(), payload_slice());
  endtask

  // Packs the pending slices into data words, most significant slice first,
  // padding the tail with idle codes. Other words may be slipped in between.
  task automatic send_slices(input bit interleave);
    logic [8:0] trio[3];
    while (pending_slices.size() != 0) begin
      for (int i = 0; i < 3; i++)
        trio[i] = (pending_slices.size() != 0) ? pending_slices.pop_front()
                                               : phfd_pkg::CODE_IDLE;
      send_word({phfd_pkg::TAG_DATA, trio[0], trio[1], trio[2]});
      if (interleave && $urandom_range(0, 99) < 15) send_word(side_word());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every word class at the extremes of its fields, plus data and idle
  // slices arriving with no frame open, which must produce nothing.
  task automatic test_word_classes();
    send_word(32'h4800_0000);
    send_word(32'h4FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hC800_0000);
    send_word(32'h0000_0000);
    send_word(32'h3FFF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word({phfd_pkg::TAG_DATA, 9'h1FF, 9'h000, 9'h0AA});
    send_word({phfd_pkg::TAG_DATA, phfd_pkg::CODE_IDLE, phfd_pkg::CODE_IDLE,
               phfd_pkg::CODE_IDLE});
    send_word(32'h4812_3456);
    pause_until_drained();
  endtask

  // Framing: an end of frame with no frame open, a start of frame inside a
  // frame that abandons a half-built hit but keeps buffered ones, an idle
  // code in the middle of a hit, an empty frame, and hits at the extremes of
  // column, row and time over threshold.
  task automatic test_frame_codes();
    queue_slice(phfd_pkg::CODE_EOF);
    send_slices(1'b0);
    send_word(32'h4800_0001);

    queue_slice(phfd_pkg::CODE_SOF);
    push_hit(9'h0FF, 9'h1FF, 9'h1FF, 9'h1FF);
    push_hit(9'h000, 9'h000, 9'h000, 9'h000);
    queue_slice(9'h055);
    queue_slice(9'h0AA);
    queue_slice(phfd_pkg::CODE_SOF);
    push_hit(9'h1FE, 9'h001, 9'h0FD, 9'h100);
    queue_slice(9'h012);
    queue_slice(phfd_pkg::CODE_IDLE);
    queue_slice(9'h034);
    queue_slice(9'h156);
    queue_slice(9'h078);
    queue_slice(phfd_pkg::CODE_EOF);
    queue_slice(phfd_pkg::CODE_EOF);
    send_slices(1'b0);

    queue_slice(phfd_pkg::CODE_SOF);
    queue_slice(phfd_pkg::CODE_EOF);
    send_slices(1'b0);
    send_word(32'h8765_4321);
    pause_until_drained();
  endtask

  // One more hit than the buffer holds: the extra hit is dropped with an
  // error and the flush returns a full buffer from a single word. The sender
  // then waits for every result before going on.
  task automatic test_full_buffer();
    queue_slice(phfd_pkg::CODE_SOF);
    repeat (HIT_DEPTH + 1) push_random_hit();
    queue_slice(phfd_pkg::CODE_EOF);
    send_slices(1'b0);
    pause_until_drained();
  endtask

  // Mostly well-formed frames with random hit content and random alignment,
  // mixed with other word classes, broken slice sequences and raw noise.
  task automatic test_random_traffic();
    int first;
    int pick;
    int n_hits;
    first = words_sent;
    while (words_sent - first < RANDOM_ITEMS) begin
      steady_send = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) n_hits = $urandom_range(0, 6);
        else if (pick < 95) n_hits = $urandom_range(7, HIT_DEPTH);
        else n_hits = $urandom_range(HIT_DEPTH + 1, HIT_DEPTH + 4);
        repeat ($urandom_range(0, 2)) queue_slice(phfd_pkg::CODE_IDLE);
        queue_slice(phfd_pkg::CODE_SOF);
        repeat (n_hits) push_random_hit();
        queue_slice(phfd_pkg::CODE_EOF);
        send_slices(1'b1);
      end else if (pick < 70) begin
        send_word(side_word());
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 12)) queue_slice(noisy_slice());
        send_slices(1'b1);
      end else begin
        send_word($urandom);
      end
    end
    steady_send = 1'b0;
    pause_until_drained();
  endtask

  // Framing errors piled up back to back: words of three start-of-frame
  // codes, a word of three end-of-frame codes, and restarted frames, with
  // the running count checked on timestamp, hit and trigger results.
  task automatic test_error_count();
    steady_send = 1'b1;
    repeat (4) send_word({phfd_pkg::TAG_DATA, phfd_pkg::CODE_SOF, phfd_pkg::CODE_SOF,
                          phfd_pkg::CODE_SOF});
    steady_send = 1'b0;
    send_word({phfd_pkg::TAG_DATA, phfd_pkg::CODE_EOF, phfd_pkg::CODE_EOF,
               phfd_pkg::CODE_EOF});
    send_word(32'h4FFF_FFFF);
    queue_slice(phfd_pkg::CODE_SOF);
    push_random_hit();
    queue_slice(phfd_pkg::CODE_SOF);
    push_random_hit();
    queue_slice(phfd_pkg::CODE_EOF);
    send_slices(1'b0);
    send_word(32'hFFFF_FFFF);
    pause_until_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_word_classes();
    test_frame_codes();
    test_full_buffer();
    test_random_traffic();
    test_error_count();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/phfd_pkg.sv
hdl/phfd_ram.sv
hdl/phfd_front.sv
hdl/phfd_queue.sv
hdl/phfd_back.sv
hdl/pixel_hit_frame_decoder.sv
sim/tb_pixel_hit_frame_decoder.sv
